### hdl/dcct_pkg.sv
`timescale 1ns / 1ps

package dcct_pkg;

   // field widths
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned TIMEOUT_W  = 31;
   localparam int unsigned CTRL_ERR_W = 8;
   localparam int unsigned CODE_W     = 3;
   localparam int unsigned CMD_W      = 2;
   localparam int unsigned CSR_IDX_W  = 8;

   // packed stream widths
   localparam int unsigned REQ_DATA_W = 3 * WORD_W;
   localparam int unsigned RSP_BITS   = 1 + WORD_W + CODE_W + CTRL_ERR_W + 5;
   localparam int unsigned RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;

   // controller status bits
   localparam logic [WORD_W-1:0] ST_BUSY  = 32'h1;
   localparam logic [WORD_W-1:0] ST_DONE  = 32'h2;
   localparam logic [WORD_W-1:0] ST_ERR   = 32'h4;
   localparam logic [WORD_W-1:0] ST_KNOWN = 32'h7;

   // register reset values
   localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET  = 31'd30000;
   localparam logic [CTRL_ERR_W-1:0] MAX_ERR_RESET  = 8'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_CTRL_ERR  = 8'd1;

   typedef enum logic [CMD_W-1:0] {
      CMD_BEGIN    = 2'd0,
      CMD_IRQ      = 2'd1,
      CMD_WATCHDOG = 2'd2
   } cmd_type;

   typedef enum logic [CODE_W-1:0] {
      RC_OK      = 3'd0,
      RC_CTRL    = 3'd1,
      RC_UNEXP   = 3'd2,
      RC_TIMEOUT = 3'd3,
      RC_QUAR    = 3'd4
   } code_type;

   // code plus controller error number
   typedef struct packed {
      logic [CODE_W-1:0]     code;
      logic [CTRL_ERR_W-1:0] err;
   } result_type;

   // one response word, lowest field last
   typedef struct packed {
      logic                  is_quarantined;
      logic                  is_active;
      logic                  unexpected_irq;
      logic                  clear_status;
      logic                  completed;
      logic [CTRL_ERR_W-1:0] controller_error;
      logic [CODE_W-1:0]     result_code;
      logic [WORD_W-1:0]     generation;
      logic                  started;
   } rsp_type;

   // status and error decode into a result
   function automatic result_type decode_status(
      input logic [WORD_W-1:0]     st,
      input logic [WORD_W-1:0]     er,
      input logic [CTRL_ERR_W-1:0] max_err
   );
      result_type r;
      r.code = RC_UNEXP;
      r.err  = '0;
      if ((st & ~ST_KNOWN) != '0) begin
         r.code = RC_UNEXP;
      end else if (er != '0) begin
         if (er <= {{(WORD_W-CTRL_ERR_W){1'b0}}, max_err}) begin
            r.code = RC_CTRL;
            r.err  = er[CTRL_ERR_W-1:0];
         end
      end else if ((st & (ST_BUSY | ST_ERR)) == '0 && (st & ST_DONE) != '0) begin
         r.code = RC_OK;
      end
      return r;
   endfunction

endpackage

### hdl/dma_command_completion_tracker_core.sv
`timescale 1ns / 1ps

// channel   dir  handshake              payload
// req_      in   req_tvalid/req_tready  tdata: status, error, now; tuser: cmd
// rsp_      out  rsp_tvalid/rsp_tready  tdata: one event result
// csr_      in   csr_valid/csr_ready    csr_index, csr_data
//
// one event per cycle sustained while responses are accepted; each word is registered
// in the input register and is then decoded into the result register
// tracker state updates as the word leaves the input register, so the next
// word always sees it
// reset clears all control state and loads the register defaults
// a stalled response holds both stages and drops req_tready only when full
module dma_command_completion_tracker_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // status_word [31:0], error_word [63:32], now_ticks [95:64]
   input  logic [dcct_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd [1:0]
   input  logic [dcct_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // started [0], generation [32:1], result_code [35:33],
   // controller_error [43:36], completed [44], clear_status [45],
   // unexpected_irq [46], is_active [47], is_quarantined [48], zero above
   output logic [dcct_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dcct_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dcct_pkg::WORD_W-1:0]         csr_data
);
   import dcct_pkg::*;

   // configuration
   logic [TIMEOUT_W-1:0]  timeout_ff;
   logic [CTRL_ERR_W-1:0] max_err_ff;

   // input stage
   logic                  in_valid_ff;
   logic [CMD_W-1:0]      in_cmd_ff;
   logic [WORD_W-1:0]     in_st_ff;
   logic [WORD_W-1:0]     in_er_ff;
   logic [WORD_W-1:0]     in_now_ff;

   // tracker state
   logic [WORD_W-1:0]     gen_ff, gen_in;
   logic                  active_ff, active_in;
   logic                  quar_ff, quar_in;
   result_type            stored_ff, stored_in;
   logic                  late_ff, late_in;
   logic [WORD_W-1:0]     deadline_ff, deadline_in;

   // output stage
   logic                  out_valid_ff;
   rsp_type               out_ff, out_in;

   logic                  out_load;
   logic                  advance;
   logic                  busy_bit;
   logic                  term;
   logic                  unknown_bits;
   logic [WORD_W-1:0]     gen_inc;
   logic [WORD_W-1:0]     since_deadline;
   result_type            decoded;
   result_type            res;

   // handshake
   assign out_load   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_load;
   assign req_tready = !in_valid_ff || out_load;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-RSP_BITS){1'b0}}, out_ff};

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         max_err_ff <= MAX_ERR_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TIMEOUT_TICKS) begin
            timeout_ff <= csr_data[TIMEOUT_W-1:0];
         end else if (csr_index == CSR_MAX_CTRL_ERR) begin
            max_err_ff <= csr_data[CTRL_ERR_W-1:0];
         end
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_st_ff  <= req_tdata[WORD_W-1:0];
         in_er_ff  <= req_tdata[2*WORD_W-1:WORD_W];
         in_now_ff <= req_tdata[3*WORD_W-1:2*WORD_W];
         in_cmd_ff <= req_tuser;
      end
   end

   // shared decode terms
   assign busy_bit       = (in_st_ff & ST_BUSY) != '0;
   assign unknown_bits   = (in_st_ff & ~ST_KNOWN) != '0;
   assign term           = (in_st_ff & (ST_DONE | ST_ERR)) != '0 || in_er_ff != '0;
   assign decoded        = decode_status(in_st_ff, in_er_ff, max_err_ff);
   assign gen_inc        = gen_ff + 32'd1;
   assign since_deadline = in_now_ff - deadline_ff;

   // event decision
   always_comb begin
      gen_in      = gen_ff;
      active_in   = active_ff;
      quar_in     = quar_ff;
      stored_in   = stored_ff;
      late_in     = late_ff;
      deadline_in = deadline_ff;
      res         = stored_ff;
      out_in      = '0;

      unique case (cmd_type'(in_cmd_ff))
         CMD_BEGIN: begin
            res = '{code: RC_OK, err: '0};
            if (quar_ff) begin
               res.code = RC_QUAR;
            end else if (active_ff || busy_bit) begin
               res = '{code: RC_CTRL, err: 8'd1};
            end else if (unknown_bits || (in_st_ff & ST_ERR) != '0 || in_er_ff != '0) begin
               res = decoded;
               out_in.clear_status = 1'b1;
            end else begin
               out_in.clear_status = (in_st_ff & ST_DONE) != '0;
               gen_in         = (gen_inc == '0) ? 32'd1 : gen_inc;
               active_in      = 1'b1;
               stored_in      = '{code: RC_UNEXP, err: '0};
               deadline_in    = in_now_ff + {1'b0, timeout_ff};
               out_in.started = 1'b1;
            end
         end
         CMD_IRQ: begin
            late_in = 1'b0;
            if (!active_ff && quar_ff && term) begin
               out_in.clear_status = 1'b1;
               if (!busy_bit) begin
                  quar_in = 1'b0;
               end
            end else if (active_ff && term) begin
               out_in.clear_status = 1'b1;
               stored_in        = decoded;
               quar_in          = busy_bit;
               active_in        = 1'b0;
               out_in.completed = 1'b1;
            end else begin
               out_in.clear_status   = term;
               out_in.unexpected_irq = !late_ff;
            end
            res = stored_in;
         end
         CMD_WATCHDOG: begin
            if (active_ff) begin
               if (term) begin
                  stored_in        = decoded;
                  quar_in          = busy_bit;
                  active_in        = 1'b0;
                  out_in.completed = 1'b1;
                  if (!busy_bit) begin
                     late_in = 1'b1;
                  end
               end else if (!since_deadline[WORD_W-1]) begin
                  // wrapping deadline reached
                  stored_in        = '{code: RC_TIMEOUT, err: '0};
                  quar_in          = 1'b1;
                  active_in        = 1'b0;
                  out_in.completed = 1'b1;
               end
            end
            res = stored_in;
         end
         default: begin
            res = stored_ff;
         end
      endcase

      out_in.generation       = gen_in;
      out_in.result_code      = res.code;
      out_in.controller_error = res.err;
      out_in.is_active        = active_in;
      out_in.is_quarantined   = quar_in;
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff      <= '0;
         active_ff   <= 1'b0;
         quar_ff     <= 1'b0;
         stored_ff   <= '0;
         late_ff     <= 1'b0;
         deadline_ff <= '0;
      end else if (advance) begin
         gen_ff      <= gen_in;
         active_ff   <= active_in;
         quar_ff     <= quar_in;
         stored_ff   <= stored_in;
         late_ff     <= late_in;
         deadline_ff <= deadline_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule

### hdl/dcct_checker.sv
`timescale 1ns / 1ps

module dcct_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [dcct_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import dcct_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_type'(rsp_tdata[RSP_BITS-1:0]);

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed under stall");

   // a new generation is active, nonzero and reports ok
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.started |->
         rsp.is_active && !rsp.is_quarantined && rsp.generation != '0
         && rsp.result_code == RC_OK)
      else $error("started word inconsistent");

   // completion leaves nothing outstanding
   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.completed |-> !rsp.is_active && !rsp.started
         && !rsp.unexpected_irq)
      else $error("completed word still active");

   // active and quarantined never together
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.is_active && rsp.is_quarantined))
      else $error("active while quarantined");

   // controller error number only with a controller error code
   a_err_num: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.controller_error != '0 |-> rsp.result_code == RC_CTRL)
      else $error("error number without controller error");

endmodule

bind dma_command_completion_tracker_core dcct_checker u_dcct_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
